/* sv/bslp_pkg.sv */
`default_nettype none

package bslp_pkg;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned LEVEL_W = 3;
  localparam int unsigned EVENT_W = 3;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CFG_IDX_W = 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MIN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_MIN  = 1'b1;

  localparam logic [EVENT_W-1:0] EV_NONE = '0;

  localparam logic [CFG_W-1:0] SHORT_MIN_RST = 16'd200;
  localparam logic [CFG_W-1:0] LONG_MIN_RST  = 16'd1000;

  // what a lane found in the current word
  typedef struct packed {
    logic hit;
    logic is_long;
  } lane_res_t;

  // how the merge stage lets a lane commit
  typedef struct packed {
    logic take;        // scan reached this lane
    logic keep_level;  // lane produced the event: hold last level
  } lane_upd_t;

endpackage

`default_nettype wire

/* sv/bslp_lane.sv */
`default_nettype none

module bslp_lane (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            level_i,
  input  wire logic [bslp_pkg::TIME_W-1:0]     time_ms_i,
  input  wire logic [bslp_pkg::CFG_W-1:0]      short_min_i,
  input  wire logic [bslp_pkg::CFG_W-1:0]      long_min_i,
  input  wire bslp_pkg::lane_upd_t             upd_i,
  output bslp_pkg::lane_res_t                  res_o
);
  import bslp_pkg::*;

  logic              prev_q, armed_q, ldone_q;
  logic [TIME_W-1:0] stamp_q;

  logic              fall, rise, armed_e, ldone_e;
  logic              short_hit, long_hit;
  logic              armed_d, ldone_d;
  logic [TIME_W-1:0] stamp_d, held;

  always_comb begin
    fall    = !level_i && prev_q;
    stamp_d = fall ? time_ms_i : stamp_q;
    armed_e = fall || armed_q;
    ldone_e = !fall && ldone_q;
    held    = time_ms_i - stamp_d;  // wraps mod 2^32

    rise      = level_i && !prev_q && armed_e;
    short_hit = rise && !ldone_e && (held > {{(TIME_W-CFG_W){1'b0}}, short_min_i});
    long_hit  = !level_i && armed_e && !ldone_e
                && (held >= {{(TIME_W-CFG_W){1'b0}}, long_min_i});

    armed_d = armed_e && !rise;
    ldone_d = ldone_e || long_hit;

    res_o.hit     = short_hit || long_hit;
    res_o.is_long = long_hit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= 1'b1;
      armed_q <= 1'b0;
      ldone_q <= 1'b0;
      stamp_q <= '0;
    end else if (upd_i.take) begin
      stamp_q <= stamp_d;
      armed_q <= armed_d;
      ldone_q <= ldone_d;
      if (!upd_i.keep_level) begin
        prev_q <= level_i;
      end
    end
  end

endmodule

`default_nettype wire

/* sv/bslp_merge.sv */
`default_nettype none

module bslp_merge #(
  parameter int unsigned BUTTON_COUNT = 3
) (
  input  wire logic                               accept_i,
  input  wire bslp_pkg::lane_res_t [BUTTON_COUNT-1:0] res_i,
  output bslp_pkg::lane_upd_t [BUTTON_COUNT-1:0]  upd_o,
  output logic [bslp_pkg::EVENT_W-1:0]            event_o
);
  import bslp_pkg::*;

  logic found;

  // first lane with a hit wins; lanes past it are left alone
  always_comb begin
    found   = 1'b0;
    event_o = EV_NONE;
    for (int i = 0; i < int'(BUTTON_COUNT); i++) begin
      upd_o[i].take       = accept_i && !found;
      upd_o[i].keep_level = res_i[i].hit;
      if (!found && res_i[i].hit) begin
        found   = 1'b1;
        event_o = res_i[i].is_long ? EVENT_W'(2 * i + 2) : EVENT_W'(2 * i + 1);
      end
    end
  end

endmodule

`default_nettype wire

/* sv/button_short_long_press_classifier.sv */
`default_nettype none

// Short/long press classifier for BUTTON_COUNT active-low buttons. Each input
// word carries a wrapping millisecond timestamp and the pin levels; each one
// yields exactly one output word with event_res (0 none, 2i+1 short press of
// button i, 2i+2 long press). One lane per button evaluates its edge and hold
// time in parallel; a priority merge picks the lowest-index event and decides
// which lanes commit state, so the scan-order semantics hold. Throughput is one
// word per clock unless the output stalls; results are registered in the output
// register. The rate is set by the per-button state update (32-bit hold
// subtract and compare, then the priority merge) being combinational.
// in_stall_o rises only while a result sits in the output register and the
// consumer stalls. Thresholds are written through cfg_we_i/cfg_idx_i/cfg_data_i
// (0 short_min_ms, reset 200; 1 long_min_ms, reset 1000) and should change only
// while the block is idle. Buttons past the three level bits read as pressed.
module button_short_long_press_classifier #(
  parameter int unsigned BUTTON_COUNT = 3
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [bslp_pkg::TIME_W-1:0]       time_ms_i,
  input  wire logic [bslp_pkg::LEVEL_W-1:0]      levels_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [bslp_pkg::EVENT_W-1:0]           event_res_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [bslp_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [bslp_pkg::CFG_W-1:0]        cfg_data_i
);
  import bslp_pkg::*;

  // thresholds
  logic [CFG_W-1:0] short_min_q, long_min_q;

  // output register
  logic               out_valid_q, out_valid_d;
  logic [EVENT_W-1:0] event_q;

  logic               accept;
  logic [EVENT_W-1:0] event_d;

  lane_res_t [BUTTON_COUNT-1:0] lane_res;
  lane_upd_t [BUTTON_COUNT-1:0] lane_upd;

  // new word accepted whenever the output slot is free or being drained
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_d = accept || (out_valid_q && out_stall_i);

  assign out_valid_o = out_valid_q;
  assign event_res_o = event_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_min_q <= SHORT_MIN_RST;
      long_min_q  <= LONG_MIN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SHORT_MIN: short_min_q <= cfg_data_i;
        CFG_LONG_MIN:  long_min_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      event_q <= event_d;
    end
  end

  // one lane per button
  for (genvar g = 0; g < BUTTON_COUNT; g++) begin : g_lane
    logic lvl;
    if (g < LEVEL_W) begin : g_pin
      assign lvl = levels_i[g];
    end else begin : g_nopin
      assign lvl = 1'b0;  // no pin bit: reads as pressed
    end

    bslp_lane u_lane (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .level_i     (lvl),
      .time_ms_i   (time_ms_i),
      .short_min_i (short_min_q),
      .long_min_i  (long_min_q),
      .upd_i       (lane_upd[g]),
      .res_o       (lane_res[g])
    );
  end

  bslp_merge #(
    .BUTTON_COUNT (BUTTON_COUNT)
  ) u_merge (
    .accept_i (accept),
    .res_i    (lane_res),
    .upd_o    (lane_upd),
    .event_o  (event_d)
  );

endmodule

`default_nettype wire

/* sv/bslp_checker.sv */
`default_nettype none

module bslp_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_valid_i,
  input wire logic                         in_stall_o,
  input wire logic                         out_valid_o,
  input wire logic                         out_stall_i,
  input wire logic [bslp_pkg::EVENT_W-1:0] event_res_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(event_res_o))
    else $error("stalled output word changed");

  // input stalls only behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with free output slot");

  // every accepted word gives a result next cycle
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted word produced no result");

  // a drained result with no new word leaves nothing behind
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !(in_valid_i && !in_stall_o) |=> !out_valid_o)
    else $error("result repeated");

endmodule

bind button_short_long_press_classifier bslp_checker u_bslp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .event_res_o (event_res_o)
);

`default_nettype wire
